// File: src/sha256_pkg.sv
// SHA-256 stream hasher: shared types, constants and round functions.
package sha256_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned QueueDepth = 4;
	localparam logic [5:0] DigestBytesRst = 6'd32;
	localparam logic [5:0] DigestMax = 6'd32;
	localparam logic [7:0] PadByte = 8'h80;

	typedef logic [WordW-1:0] word_t;

	// front-to-back command
	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_PAD,
		CMD_LEN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] data;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ROUND,
		B_ADD,
		B_EMIT
	} back_state_t;

	localparam word_t InitH [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	function automatic word_t round_k(input logic [5:0] r);
		word_t k;
		unique case (r)
			6'd0: k = 32'h428A2F98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hB5C0FBCF;
			6'd3: k = 32'hE9B5DBA5; 6'd4: k = 32'h3956C25B; 6'd5: k = 32'h59F111F1;
			6'd6: k = 32'h923F82A4; 6'd7: k = 32'hAB1C5ED5; 6'd8: k = 32'hD807AA98;
			6'd9: k = 32'h12835B01; 6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
			6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE; 6'd14: k = 32'h9BDC06A7;
			6'd15: k = 32'hC19BF174; 6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
			6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC; 6'd20: k = 32'h2DE92C6F;
			6'd21: k = 32'h4A7484AA; 6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
			6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D; 6'd26: k = 32'hB00327C8;
			6'd27: k = 32'hBF597FC7; 6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
			6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27B70A85;
			6'd33: k = 32'h2E1B2138; 6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
			6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB; 6'd38: k = 32'h81C2C92E;
			6'd39: k = 32'h92722C85; 6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
			6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3; 6'd44: k = 32'hD192E819;
			6'd45: k = 32'hD6990624; 6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
			6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08; 6'd50: k = 32'h2748774C;
			6'd51: k = 32'h34B0BCB5; 6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
			6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3; 6'd56: k = 32'h748F82EE;
			6'd57: k = 32'h78A5636F; 6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
			6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB; 6'd62: k = 32'hBEF9A3F7;
			6'd63: k = 32'hC67178F2;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WordW - n));
	endfunction

endpackage

// File: src/sha256_front.sv
// Front end: accepts input transactions and expands a finish into padding commands.
module sha256_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_mode,
	input  logic [7:0]          in_data,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output sha256_pkg::cmd_t    cmd
);
	import sha256_pkg::*;

	// fill tracked here so the padding run length is known up front
	logic [5:0] fill_q;
	logic       pad_q;
	logic       pad_first_q;

	assign in_ready = !pad_q && cmd_ready;
	// a finish carries no byte of its own; it only starts the padding run
	assign cmd_valid = pad_q || (in_valid && !in_mode);

	always_comb begin
		cmd.data = in_data;
		cmd.kind = CMD_BYTE;
		if (pad_q) begin
			cmd.data = pad_first_q ? PadByte : 8'h00;
			cmd.kind = (!pad_first_q && fill_q == 6'd56) ? CMD_LEN : CMD_PAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pad_q <= 1'b0;
			pad_first_q <= 1'b0;
		end else if (pad_q) begin
			if (cmd_ready) begin
				pad_first_q <= 1'b0;
				if (cmd.kind == CMD_LEN) begin
					pad_q <= 1'b0;
					fill_q <= '0;
				end else begin
					fill_q <= fill_q + 6'd1;
				end
			end
		end else if (in_valid && in_ready) begin
			if (in_mode) begin
				pad_q <= 1'b1;
				pad_first_q <= 1'b1;
			end else begin
				fill_q <= fill_q + 6'd1;
			end
		end
	end

endmodule

// File: src/sha256_queue.sv
// Small command queue between front and back ends.
module sha256_queue #(
	parameter int unsigned Depth = sha256_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  sha256_pkg::cmd_t wr_cmd,
	output logic             rd_valid,
	input  logic             rd_ready,
	output sha256_pkg::cmd_t rd_cmd
);
	import sha256_pkg::*;

	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

	cmd_t          mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign rd_cmd = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
			if (rd)
				rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

endmodule

// File: src/sha256_back.sv
// Back end: packs bytes, runs the 64 rounds, emits the digest.
module sha256_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  sha256_pkg::cmd_t cmd,
	input  logic [5:0]       digest_bytes,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last
);
	import sha256_pkg::*;

	back_state_t state_q, state_d;
	word_t       h_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [63:0] len_q;
	logic        fin_q;
	logic [5:0]  k_q, n_q;

	logic        take;
	word_t       w_new, w_cur, t0, t1, s0, s1, a2, a15;
	logic [5:0]  n_cap;

	assign n_cap = (digest_bytes > DigestMax) ? DigestMax : digest_bytes;

	// ring rotates every round, so w_q[0] is always the current word
	always_comb begin
		a2 = w_q[14];
		a15 = w_q[1];
		s0 = rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3);
		s1 = rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		w_cur = w_q[0];
		t0 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ (v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]))) + round_k(rnd_q) + w_cur;
		t1 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ (((v_q[0] | v_q[1]) & v_q[2]) | (v_q[0] & v_q[1]));
	end

	always_comb begin
		state_d = state_q;
		cmd_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			B_IDLE: cmd_ready = 1'b1;
			B_ROUND: if (rnd_q == 6'd63) state_d = B_ADD;
			B_ADD: state_d = (fin_q && n_q != '0) ? B_EMIT : B_IDLE;
			B_EMIT: begin
				out_valid = 1'b1;
				if (out_ready && k_q == n_q - 6'd1)
					state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
		if (state_q == B_IDLE && cmd_valid &&
				(cmd.kind == CMD_LEN || fill_q == 6'd63))
			state_d = B_ROUND;
	end

	assign take = cmd_valid && cmd_ready;

	always_comb begin
		word_t hw;
		hw = h_q[k_q[4:2]];
		unique case (k_q[1:0])
			2'd0: out_byte = hw[31:24];
			2'd1: out_byte = hw[23:16];
			2'd2: out_byte = hw[15:8];
			2'd3: out_byte = hw[7:0];
			default: out_byte = '0;
		endcase
	end
	assign out_last = k_q == n_q - 6'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= InitH;
			fill_q <= '0;
			len_q <= '0;
			fin_q <= 1'b0;
			rnd_q <= '0;
			k_q <= '0;
			n_q <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: if (take) begin
					fin_q <= cmd.kind == CMD_LEN;
					n_q <= n_cap;
					k_q <= '0;
					rnd_q <= '0;
					v_q <= h_q;
					if (cmd.kind == CMD_LEN) begin
						w_q[14] <= len_q[63:32];
						w_q[15] <= len_q[31:0];
						fill_q <= '0;
					end else begin
						w_q[fill_q[5:2]][5'd24 - {fill_q[1:0], 3'b000} +: 8] <= cmd.data;
						fill_q <= fill_q + 6'd1;
						if (cmd.kind == CMD_BYTE)
							len_q <= len_q + 64'd8;
					end
				end
				B_ROUND: begin
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t0;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t0 + t1;
					for (int i = 0; i < 15; i++)
						w_q[i] <= w_q[i+1];
					w_q[15] <= w_new;
					// rounds 0..15 use stored words; rounds 16..63 use extended
					rnd_q <= rnd_q + 6'd1;
				end
				B_ADD: begin
					if (fin_q && n_q == '0) begin
						h_q <= InitH;
						len_q <= '0;
					end else begin
						for (int i = 0; i < 8; i++)
							h_q[i] <= h_q[i] + v_q[i];
					end
				end
				B_EMIT: if (out_ready) begin
					k_q <= k_q + 6'd1;
					if (k_q == n_q - 6'd1) begin
						h_q <= InitH;
						len_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: src/sha256_stream_hasher_top.sv
// SHA-256 stream hasher top level.
// channel | dir | tdata                      | tuser       | tlast
// s_axis  | in  | [7:0] data_byte            | [0] mode    | -
// m_axis  | out | [7:0] digest_byte          | -           | last_byte
// cfg     | in  | [5:0] digest_bytes         | -           | -
// Every 64th message byte adds a compression (64 rounds at one per cycle, then the
// chaining add). A finish adds 2 to 65 padding commands, one or two compressions,
// then one digest byte per cycle while m_axis_tready is high.
// Reset clears control state and loads the initial hash; the ring is not cleared.
// A stalled m_axis holds the back end; the front keeps filling the queue.
module sha256_stream_hasher_top #(
	parameter int unsigned QDepth = sha256_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic       s_axis_tuser,  // [0] mode
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] digest_byte
	output logic       m_axis_tlast,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata
);
	import sha256_pkg::*;

	logic [5:0] digest_bytes_q;
	logic       fq_valid, fq_ready, qb_valid, qb_ready;
	cmd_t       fq_cmd, qb_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			digest_bytes_q <= DigestBytesRst;
		else if (cfg_we)
			digest_bytes_q <= cfg_wdata;
	end

	sha256_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_mode(s_axis_tuser), .in_data(s_axis_tdata),
		.cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
	);

	sha256_queue #(.Depth(QDepth)) u_queue (
		.clk, .arst_n,
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_cmd(fq_cmd),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_cmd(qb_cmd)
	);

	sha256_back u_back (
		.clk, .arst_n,
		.cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
		.digest_bytes(digest_bytes_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_byte(m_axis_tdata), .out_last(m_axis_tlast)
	);

`ifndef SYNTHESIS
	a_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !qb_ready)
		else $error("output valid while back end takes commands");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("output continues after last byte");
	a_no_in_while_pad: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
		else $error("input taken during padding");
`endif

endmodule

// File: tb/sv/tb.sv
// Testbench for the SHA-256 stream hasher: directed and random messages checked per digest byte.
`timescale 1ns / 1ps
module tb;
	import sha256_pkg::*;

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	typedef struct {
		logic       mode;
		logic [7:0] data;
	} byte_cmd_t;

	typedef struct {
		logic [7:0] dbyte;
		logic       last;
	} digest_out_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic       s_axis_tuser = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic       cfg_we = 1'b0;
	logic [5:0] cfg_wdata = '0;

	sha256_stream_hasher_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	word_t       hash_h [8];
	word_t       msg_w [16];
	int unsigned fill_cnt;
	logic [63:0] msg_bits;
	logic [5:0]  digest_len;

	digest_out_t digest_q [$];
	int          n_fail = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          rx_hold = 0;
	logic        hold_go = 1'b0;
	logic        hold_used = 1'b0;

	function automatic word_t ror32(word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void hash_init();
		for (int i = 0; i < 8; i++) hash_h[i] = InitH[i];
		fill_cnt = 0;
		msg_bits = '0;
	endfunction

	function automatic void compress_block();
		word_t v [8];
		word_t w, s0, s1, t0, t1, x2, x15;
		for (int i = 0; i < 8; i++) v[i] = hash_h[i];
		for (int r = 0; r < 64; r++) begin
			w = msg_w[r % 16];
			if (r >= 16) begin
				x2 = msg_w[(r - 2) % 16];
				x15 = msg_w[(r - 15) % 16];
				s1 = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
				s0 = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
				w = w + s1 + msg_w[(r - 7) % 16] + s0;
				msg_w[r % 16] = w;
			end
			t0 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ (v[6] ^ (v[4] & (v[5] ^ v[6]))) + round_k(r[5:0]) + w;
			t1 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ (((v[0] | v[1]) & v[2]) | (v[0] & v[1]));
			for (int j = 7; j > 0; j--) v[j] = v[j - 1];
			v[4] = v[4] + t0;
			v[0] = t0 + t1;
		end
		for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
	endfunction

	function automatic void push_msg_byte(logic [7:0] b);
		int sh;
		sh = 24 - 8 * (fill_cnt % 4);
		msg_w[fill_cnt / 4] = (msg_w[fill_cnt / 4] & ~(32'hFF << sh)) | (word_t'(b) << sh);
		fill_cnt = (fill_cnt + 1) % 64;
		if (fill_cnt == 0) compress_block();
	endfunction

	function automatic void predict_digest(byte_cmd_t c);
		int n;
		digest_out_t d;
		if (c.mode == MODE_APPEND) begin
			msg_bits = msg_bits + 64'd8;
			push_msg_byte(c.data);
			return;
		end
		push_msg_byte(PadByte);
		while (fill_cnt != 56) push_msg_byte(8'h00);
		msg_w[14] = msg_bits[63:32];
		msg_w[15] = msg_bits[31:0];
		compress_block();
		n = (digest_len > DigestMax) ? int'(DigestMax) : int'(digest_len);
		for (int k = 0; k < n; k++) begin
			d.dbyte = 8'(hash_h[k / 4] >> (24 - 8 * (k % 4)));
			d.last = (k + 1 == n);
			digest_q.push_back(d);
		end
		hash_init();
	endfunction

	task automatic send_cmd(byte_cmd_t c);
		while (($urandom % 100) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= c.mode;
		s_axis_tdata <= c.data;
		do @(posedge clk); while (!s_axis_tready);
		predict_digest(c);
		@(negedge clk);
	endtask

	task automatic send_msg(int len, logic [7:0] fixed, bit use_fixed);
		byte_cmd_t c;
		for (int i = 0; i < len; i++) begin
			c.mode = MODE_APPEND;
			c.data = use_fixed ? fixed : 8'($urandom);
			send_cmd(c);
		end
		c.mode = MODE_FINISH;
		c.data = 8'($urandom);
		send_cmd(c);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (digest_q.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_len(logic [5:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		digest_len = v;
	endtask

	// receiver
	always @(negedge clk) begin
		if (hold_go && !hold_used) begin
			hold_used <= 1'b1;
			rx_hold <= 1000;
			m_axis_tready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= (($urandom % 100) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		digest_out_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (digest_q.size() == 0) begin
				$error("unexpected digest byte %h", m_axis_tdata);
				n_fail++;
			end else begin
				e = digest_q.pop_front();
				if (m_axis_tdata !== e.dbyte) begin
					$error("digest_byte exp %h got %h", e.dbyte, m_axis_tdata);
					n_fail++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("last_byte exp %b got %b", e.last, m_axis_tlast);
					n_fail++;
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// directed rows: message length, fill byte, digest length
	int          dir_len [10] = '{0, 3, 55, 56, 9, 64, 1, 70, 2, 0};
	logic [7:0]  dir_fill [10] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h80, 8'h00, 8'hFF, 8'h00};
	logic [5:0]  dir_dlen [10] = '{32, 32, 32, 32, 1, 31, 0, 63, 33, 32};

	initial begin
		int items;
		int base;
		int len;
		digest_out_t e;
		hash_init();
		for (int i = 0; i < 16; i++) msg_w[i] = '0;
		digest_len = DigestBytesRst;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty message, reset length: known digest
		send_msg(0, 8'h00, 1'b1);
		items = 1;
		e = digest_q[0];
		if (e.dbyte !== 8'hE3) begin
			$error("digest_byte exp %h got %h", 8'hE3, e.dbyte);
			n_fail++;
		end
		drain();

		for (int r = 1; r < 10; r++) begin
			if (dir_dlen[r] != digest_len) write_len(dir_dlen[r]);
			send_msg(dir_len[r], dir_fill[r], 1'b1);
			items += dir_len[r] + 1;
			drain();
		end

		base = items;
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 80 : 0;
			rx_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 32 : 0;
			if (ph == 0)
				write_len(6'd32);
			else if (ph == 1)
				write_len(6'($urandom_range(0, 63)));
			else
				write_len(6'($urandom_range(1, 63)));
			if (ph == 2) hold_go = 1'b1;
			for (int m = 0; m < 14; m++) begin
				len = ($urandom % 8 == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
				// occasional bare finish or stray data pattern
				send_msg(len, 8'h00, 1'b0);
				items += len + 1;
				if (items > base + 17 * (ph + 1)) break;
			end
			drain();
		end

		if (n_fail == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
